FILE: design/cpba_pkg.sv
// shared types and constants for the contiguous page bitmap allocator
// no dependencies; used by every module of the block
`default_nettype none

package cpba_pkg;

  // map capacity and field widths
  localparam int MAX_PAGES = 4096;
  localparam int PAGE_W    = 12;
  localparam int CNT_W     = 13;

  // usage map memory organization: one row holds WORD_W page bits
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int MAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = $clog2(MAP_WORDS);

  // operation codes of the func field
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic              func;
    logic [PAGE_W-1:0] head_page;
    logic [CNT_W-1:0]  page_count;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] start_page;
    logic [CNT_W-1:0]  free_pages;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic scan_init;
    logic range_init;
    logic mem_rd;
    logic scan_eval;
    logic mod_wr;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_free;
    logic refuse;
    logic scan_found;
    logic scan_last;
    logic range_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/cpba_dp.sv
// datapath: usage map memory, page counters, first-fit scan and range update
// depends on cpba_pkg; driven by cpba_ctrl through cmd_t / sts_t
`default_nettype none

module cpba_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cpba_pkg::in_item_t       in_data_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [cpba_pkg::CNT_W-1:0] cfg_data_i,
  input  wire cpba_pkg::cmd_t           cmd_i,
  output cpba_pkg::sts_t                sts_o,
  output cpba_pkg::out_item_t           out_data_o
);

  localparam int WW = cpba_pkg::WORD_W;
  localparam int BW = cpba_pkg::BIT_W;
  localparam int PW = cpba_pkg::PAGE_W;
  localparam int CW = cpba_pkg::CNT_W;
  localparam int RW = cpba_pkg::ROW_W;

  // count of set bits in one map word
  function automatic logic [BW:0] popcount(input logic [WW-1:0] v);
    logic [BW:0] c;
    c = '0;
    for (int k = 0; k < WW; k++) begin
      c = c + (BW+1)'(v[k]);
    end
    return c;
  endfunction

  // registers
  logic [CW-1:0]        total_q, used_q, used_d;
  cpba_pkg::in_item_t   item_q;
  logic [RW-1:0]        wptr_q;
  logic [CW-1:0]        run_q;
  logic [PW-1:0]        lo_q, hi_q;
  logic                 ok_q;
  logic [PW-1:0]        start_q;
  cpba_pkg::out_item_t  out_q;

  // map memory with row valid flags (an unwritten row reads as all free)
  logic [WW-1:0]        map_mem_q [cpba_pkg::MAP_WORDS];
  logic [cpba_pkg::MAP_WORDS-1:0] row_vld_q;
  logic [WW-1:0]        rdata_q;
  logic                 rvld_q;
  logic [WW-1:0]        word;

  // effective total and free count
  logic [CW-1:0]        eff_total, free_cnt, t_m1;

  // scan evaluation
  logic [PW-1:0]        base;
  logic [CW-1:0]        lim;
  logic [WW-1:0]        busy;
  logic [WW-1:0]        hit;
  logic [CW-1:0]        run_last;
  logic [BW-1:0]        fi;
  logic [PW-1:0]        end_pos;
  logic [PW-1:0]        run_start;

  // range update
  logic [BW-1:0]        lo_bit, hi_bit;
  logic [WW-1:0]        mask, new_word;
  logic [BW:0]          credit;
  logic [CW:0]          free_end;

  assign word = rvld_q ? rdata_q : '0;

  // effective total clamps to the map capacity
  always_comb begin
    eff_total = (total_q > CW'(cpba_pkg::MAX_PAGES)) ? CW'(cpba_pkg::MAX_PAGES) : total_q;
    free_cnt  = (used_q >= eff_total) ? '0 : eff_total - used_q;
    t_m1      = eff_total - CW'(1);
  end

  // status: refusal checks for the loaded transaction, scan and range progress
  always_comb begin
    free_end = {1'b0, CW'(item_q.head_page)} + {1'b0, item_q.page_count};
    sts_o.is_free = (item_q.func == cpba_pkg::FUNC_FREE);
    if (item_q.func == cpba_pkg::FUNC_FREE) begin
      sts_o.refuse = (item_q.page_count == '0) ||
                     (CW'(item_q.head_page) >= eff_total) ||
                     (free_end > {1'b0, eff_total});
    end else begin
      sts_o.refuse = (item_q.page_count == '0) || (item_q.page_count > free_cnt);
    end
    sts_o.scan_found = |hit;
    sts_o.scan_last  = (wptr_q == t_m1[PW-1:BW]);
    sts_o.range_last = (wptr_q == hi_q[PW-1:BW]);
  end

  // first-fit evaluation of one map word, pages past the total count as used
  always_comb begin
    logic          any;
    logic [BW-1:0] lu;
    logic [CW-1:0] run_i;
    base     = {wptr_q, {BW{1'b0}}};
    lim      = eff_total - {1'b0, base};
    run_last = '0;
    for (int i = 0; i < WW; i++) begin
      busy[i] = word[i] | (CW'(i) >= lim);
    end
    for (int i = 0; i < WW; i++) begin
      any = 1'b0;
      lu  = '0;
      for (int j = 0; j < WW; j++) begin
        if (j <= i && busy[j]) begin
          any = 1'b1;
          lu  = BW'(j);
        end
      end
      run_i  = any ? CW'(BW'(i) - lu) : run_q + CW'(i) + CW'(1);
      hit[i] = !busy[i] && (run_i >= item_q.page_count);
      if (i == WW-1) begin
        run_last = run_i;
      end
    end
    fi = '0;
    for (int i = WW-1; i >= 0; i--) begin
      if (hit[i]) begin
        fi = BW'(i);
      end
    end
    end_pos   = base + PW'(fi);
    run_start = PW'(({1'b0, end_pos} + CW'(1)) - item_q.page_count);
  end

  // per-word mask of the range and the modified word
  always_comb begin
    lo_bit   = (wptr_q == lo_q[PW-1:BW]) ? lo_q[BW-1:0] : '0;
    hi_bit   = (wptr_q == hi_q[PW-1:BW]) ? hi_q[BW-1:0] : BW'(WW-1);
    mask     = ({WW{1'b1}} << lo_bit) & ({WW{1'b1}} >> (BW'(WW-1) - hi_bit));
    new_word = (item_q.func == cpba_pkg::FUNC_FREE) ? (word & ~mask) : (word | mask);
    credit   = popcount(word & mask);
    if (item_q.func == cpba_pkg::FUNC_FREE) begin
      used_d = (used_q > CW'(credit)) ? used_q - CW'(credit) : '0;
    end else begin
      used_d = used_q;
    end
  end

  // map memory: one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_wr) begin
      map_mem_q[wptr_q] <= new_word;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= map_mem_q[wptr_q];
    end
  end

  // row valid flags cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (cmd_i.mod_wr) begin
        row_vld_q[wptr_q] <= 1'b1;
      end
      if (cmd_i.mem_rd) begin
        rvld_q <= row_vld_q[wptr_q];
      end
    end
  end

  // configuration and used page counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= CW'(cpba_pkg::MAX_PAGES);
      used_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_data_i;
      end
      if (cmd_i.scan_eval && sts_o.scan_found) begin
        used_q <= used_q + item_q.page_count;
      end else if (cmd_i.mod_wr) begin
        used_q <= used_d;
      end
    end
  end

  // transaction registers, row pointer and run length
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q  <= in_data_i;
      ok_q    <= 1'b0;
      start_q <= '0;
    end
    if (cmd_i.scan_init) begin
      wptr_q <= '0;
      run_q  <= '0;
    end
    if (cmd_i.range_init) begin
      lo_q   <= item_q.head_page;
      hi_q   <= PW'(CW'(item_q.head_page) + item_q.page_count - CW'(1));
      wptr_q <= item_q.head_page[PW-1:BW];
      ok_q   <= 1'b1;
    end
    if (cmd_i.scan_eval) begin
      if (sts_o.scan_found) begin
        start_q <= run_start;
        lo_q    <= run_start;
        hi_q    <= end_pos;
        wptr_q  <= run_start[PW-1:BW];
        ok_q    <= 1'b1;
      end else if (!sts_o.scan_last) begin
        wptr_q <= wptr_q + RW'(1);
        run_q  <= run_last;
      end
    end
    if (cmd_i.mod_wr && !sts_o.range_last) begin
      wptr_q <= wptr_q + RW'(1);
    end
    if (cmd_i.out_load) begin
      out_q.ok         <= ok_q;
      out_q.start_page <= start_q;
      out_q.free_pages <= free_cnt;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: design/cpba_ctrl.sv
// controller state machine: sequences check, scan, range update and result
// depends on cpba_pkg; commands cpba_dp through cmd_t and reads sts_t
`default_nettype none

module cpba_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire cpba_pkg::sts_t  sts_i,
  output cpba_pkg::cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_SREAD = 7'b0000100,
    ST_SEVAL = 7'b0001000,
    ST_RREAD = 7'b0010000,
    ST_RMOD  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.refuse) begin
          state_d = ST_DONE;
        end else if (sts_i.is_free) begin
          cmd_o.range_init = 1'b1;
          state_d          = ST_RREAD;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SREAD;
        end
      end
      ST_SREAD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_SEVAL;
      end
      ST_SEVAL: begin
        cmd_o.scan_eval = 1'b1;
        if (sts_i.scan_found) begin
          state_d = ST_RREAD;
        end else if (sts_i.scan_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SREAD;
        end
      end
      ST_RREAD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_RMOD;
      end
      ST_RMOD: begin
        cmd_o.mod_wr = 1'b1;
        if (sts_i.range_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RREAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/contiguous_page_bitmap_allocator.sv
// top level of the contiguous page bitmap allocator
// depends on cpba_pkg, cpba_ctrl and cpba_dp
`default_nettype none

// First-fit contiguous page allocator over a 4096-page usage map held in a
// 128 x 32-bit single-port memory. One transaction is worked at a time; a
// refused transaction skips the map. An allocate reads and then evaluates
// one 32-page map row at a time, then read-modify-writes each row of the
// found run; a free read-modify-writes each row that it touches. The result
// sits in an output register, so the next transaction is accepted while it
// waits. Row valid flags make the map read as all free after reset, with no
// clearing pass.
module contiguous_page_bitmap_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire cpba_pkg::in_item_t         in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output cpba_pkg::out_item_t             out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [cpba_pkg::CNT_W-1:0] cfg_data_i
);

  cpba_pkg::cmd_t cmd;
  cpba_pkg::sts_t sts;

  // sequencer
  cpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // map, counters and scan logic
  cpba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: design/cpba_checker.sv
// port-level checks for the contiguous page bitmap allocator
// depends on cpba_pkg; bound to contiguous_page_bitmap_allocator
`default_nettype none

module cpba_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire cpba_pkg::out_item_t out_data_o
);

  // one transaction at a time: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction still in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // refused or failed transaction reports start page zero
  a_refused_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |-> (out_data_o.start_page == '0))
    else $error("refused transaction with nonzero start page");

  // free count never above capacity
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_pages <= cpba_pkg::CNT_W'(cpba_pkg::MAX_PAGES)))
    else $error("free page count above capacity");

endmodule

bind contiguous_page_bitmap_allocator cpba_checker u_cpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
